### design/nand_page_spare_edc_builder_unit_macros.svh
// ---------------------------------------------------------------------------
// nand_page_spare_edc_builder_unit_macros.svh
// Assertion macros shared by the spare builder modules
// ---------------------------------------------------------------------------
`ifndef NAND_PAGE_SPARE_EDC_BUILDER_UNIT_MACROS_SVH
`define NAND_PAGE_SPARE_EDC_BUILDER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define NSEDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NSEDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/nsedc_pkg.sv
// ---------------------------------------------------------------------------
// nsedc_pkg
// Types, constants and EDC shift functions for the NAND spare builder
// ---------------------------------------------------------------------------
`default_nettype none

package nsedc_pkg;

  localparam int WORD_W   = 32;
  localparam int SPARE_W  = 64;
  localparam int EDC_W    = 26;
  localparam int PAGE_W   = 9;
  localparam int BYTE_W   = 8;
  localparam int MODE_W   = 2;
  localparam int TAIL_W   = 6;

  localparam logic [EDC_W:0]     EDC_POLY              = 27'h6954559;
  localparam logic [PAGE_W-1:0]  SMALL_PAGES_PER_BLOCK = 9'd32;
  localparam logic [PAGE_W-1:0]  BIG_PAGES_PER_BLOCK   = 9'd256;
  localparam logic [BYTE_W-1:0]  BLOCK_LOW_WRAP        = 8'hFF;
  localparam logic [BYTE_W-1:0]  FILL_BYTE             = 8'hFF;

  // controller modes
  localparam logic [MODE_W-1:0] MODE_SMALL_SMALL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SMALL_BIG   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BIG_BIG     = 2'd2;

  // one spare in flight: running edc and the spare bytes 0..7
  typedef struct packed {
    logic [EDC_W-1:0]   edc;
    logic [SPARE_W-1:0] spare_low;
    logic               blank;
  } nsedc_job_t;

  // one lfsr step with one input bit
  function automatic logic [EDC_W-1:0] edc_bit(input logic [EDC_W-1:0] s, input logic b);
    logic [EDC_W:0] t;
    t = {1'b0, s} ^ {{EDC_W{1'b0}}, b};
    if (t[0]) begin
      t = t ^ EDC_POLY;
    end
    return t[EDC_W:1];
  endfunction

  // 32 bits, lsb first
  function automatic logic [EDC_W-1:0] edc_feed32(input logic [EDC_W-1:0] s,
                                                  input logic [WORD_W-1:0] d);
    logic [EDC_W-1:0] r;
    r = s;
    for (int k = 0; k < WORD_W; k++) begin
      r = edc_bit(r, d[k]);
    end
    return r;
  endfunction

  // short tail, lsb first
  function automatic logic [EDC_W-1:0] edc_feed6(input logic [EDC_W-1:0] s,
                                                 input logic [TAIL_W-1:0] d);
    logic [EDC_W-1:0] r;
    r = s;
    for (int k = 0; k < TAIL_W; k++) begin
      r = edc_bit(r, d[k]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/nsedc_word_if.sv
// ---------------------------------------------------------------------------
// nsedc_word_if
// Page word channel: one data word per item, last and blank flags
// ---------------------------------------------------------------------------
`default_nettype none

interface nsedc_word_if;
  import nsedc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  logic              last_word;
  logic              page_blank;

  modport source (output valid, data_word, last_word, page_blank, input ready);
  modport sink   (input valid, data_word, last_word, page_blank, output ready);
endinterface

`default_nettype wire

### design/nsedc_spare_if.sv
// ---------------------------------------------------------------------------
// nsedc_spare_if
// Spare channel: 16 spare bytes per item as two 64-bit halves
// ---------------------------------------------------------------------------
`default_nettype none

interface nsedc_spare_if;
  import nsedc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPARE_W-1:0] spare_low;
  logic [SPARE_W-1:0] spare_high;

  modport source (output valid, spare_low, spare_high, input ready);
  modport sink   (input valid, spare_low, spare_high, output ready);
endinterface

`default_nettype wire

### design/nsedc_spare_pipe.sv
// ---------------------------------------------------------------------------
// nsedc_spare_pipe
// Runs the edc over the spare bytes, a 32-bit chunk in stages 2 and 3 and
// the tail in the output register, which holds the finished spare
// ---------------------------------------------------------------------------
`default_nettype none

`include "nand_page_spare_edc_builder_unit_macros.svh"

module nsedc_spare_pipe (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               job_load,
  input  wire nsedc_pkg::nsedc_job_t job,
  output logic                    job_ready,
  nsedc_spare_if.source           spare_ch
);
  import nsedc_pkg::*;

  nsedc_job_t st1;
  nsedc_job_t st2;
  nsedc_job_t st3;
  logic       v1;
  logic       v2;
  logic       v3;
  logic       out_valid;
  logic [SPARE_W-1:0] spare_low;
  logic [SPARE_W-1:0] spare_high;

  logic out_take;
  logic take3;
  logic take2;
  logic take1;
  logic [EDC_W-1:0] edc_tail;
  logic [EDC_W-1:0] edc_final;

  // a stage takes new contents when empty or when its item moves on
  assign out_take  = !out_valid || spare_ch.ready;
  assign take3     = !v3 || out_take;
  assign take2     = !v2 || take3;
  assign take1     = !v1 || take2;
  assign job_ready = take1;

  // last chunk: spare bytes 8..11 are zero, then six zero bits of byte 12
  assign edc_tail  = edc_feed6(edc_feed32(st3.edc, ~{WORD_W{1'b0}}), ~{TAIL_W{1'b0}});
  assign edc_final = ~edc_tail;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take1) begin
        v1 <= job_load;
      end
      if (take2) begin
        v2 <= v1;
      end
      if (take3) begin
        v3 <= v2;
      end
      if (out_take) begin
        out_valid <= v3;
      end
    end
  end

  // stage payloads: bytes 0..3, then bytes 4..7, then the tail
  always_ff @(posedge clk) begin
    if (take1 && job_load) begin
      st1 <= job;
    end
    if (take2 && v1) begin
      st2 <= {edc_feed32(st1.edc, ~st1.spare_low[WORD_W-1:0]), st1.spare_low, st1.blank};
    end
    if (take3 && v2) begin
      st3 <= {edc_feed32(st2.edc, ~st2.spare_low[SPARE_W-1:WORD_W]), st2.spare_low,
              st2.blank};
    end
    if (out_take && v3) begin
      if (st3.blank) begin
        spare_low  <= '1;
        spare_high <= '1;
      end else begin
        spare_low  <= st3.spare_low;
        spare_high <= {edc_final, {(SPARE_W - EDC_W){1'b0}}};
      end
    end
  end

  assign spare_ch.valid      = out_valid;
  assign spare_ch.spare_low  = spare_low;
  assign spare_ch.spare_high = spare_high;

  // a spare with anything in bytes 8..11 must be a blank spare
  `NSEDC_ASSERT_NOW(a_blank_form, out_valid && spare_high[WORD_W-1:0] != '0, spare_high == '1 && spare_low == '1, "spare bytes 8..11 set on a non-blank spare")
  // the last stage keeps its item while the output register is held
  `NSEDC_ASSERT_NEXT(a_stage3_hold, v3 && !out_take, v3, "stage 3 item dropped under stall")
endmodule

`default_nettype wire

### design/nand_page_spare_edc_builder_unit.sv
// ---------------------------------------------------------------------------
// nand_page_spare_edc_builder_unit
// NAND page spare builder: edc over page words plus spare, block numbering
// ---------------------------------------------------------------------------
// Usage:
//   word_ch carries a page as 32-bit words, one item per cycle while
//   ready is high; last_word marks the final word and page_blank is sampled
//   with it. Every word is folded into the 26-bit edc register in the cycle
//   it is accepted (one unrolled 32-bit lfsr update). A last word steps the
//   page and block counters and starts one spare, which then runs through
//   three stages (the job, spare bytes 0..3, bytes 4..7) and the output
//   register (bytes 8..12), where it shows on spare_ch. Throughput is one
//   word per cycle while word_ch.ready is high.
//   A stalled spare_ch holds its item; the stages behind it keep filling,
//   so up to four spares can be in flight before word_ch.ready drops.
//   controller_mode is written via cfg_wr_en/cfg_wr_data, by the user only
//   while idle (not enforced by the block). Synchronous reset clears the edc,
//   the counters, the mode and all valid flags; no clearing pass is needed.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nand_page_spare_edc_builder_unit_macros.svh"

module nand_page_spare_edc_builder_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [nsedc_pkg::MODE_W-1:0]  cfg_wr_data,
  nsedc_word_if.sink                         word_ch,
  nsedc_spare_if.source                      spare_ch
);
  import nsedc_pkg::*;

  logic [MODE_W-1:0] controller_mode;
  logic [EDC_W-1:0]  edc_shift;
  logic [PAGE_W-1:0] page_in_block;
  logic [BYTE_W-1:0] block_low;
  logic [BYTE_W-1:0] block_high;

  logic              word_take;
  logic              job_load;
  logic              job_ready;
  logic              small_mode;
  logic [EDC_W-1:0]  edc_word;
  logic [PAGE_W-1:0] page_step;
  logic [PAGE_W-1:0] page_in_block_next;
  logic [BYTE_W-1:0] block_low_next;
  logic [BYTE_W-1:0] block_high_next;
  logic [SPARE_W-1:0] spare_bytes;
  nsedc_job_t        job;

  assign word_ch.ready = job_ready;
  assign word_take     = word_ch.valid && job_ready;
  assign job_load      = word_take && word_ch.last_word;
  assign small_mode    = (controller_mode == MODE_SMALL_SMALL) ||
                         (controller_mode == MODE_SMALL_BIG);

  // edc over the inverted word, lsb first
  assign edc_word = edc_feed32(edc_shift, ~word_ch.data_word);

  // page and block counter step for a last word
  always_comb begin
    page_step       = page_in_block;
    block_low_next  = block_low;
    block_high_next = block_high;
    if (small_mode) begin
      if (page_in_block >= SMALL_PAGES_PER_BLOCK) begin
        block_low_next = block_low + 8'd1;
        page_step      = '0;
      end
      if (block_low_next == BLOCK_LOW_WRAP) begin
        block_high_next = block_high + 8'd1;
        block_low_next  = '0;
      end
    end else begin
      if (page_in_block >= BIG_PAGES_PER_BLOCK) begin
        block_low_next = block_low + 8'd1;
        page_step      = '0;
      end
    end
    page_in_block_next = page_step + 9'd1;
  end

  // spare bytes 0..7 per layout
  always_comb begin
    spare_bytes = '0;
    case (controller_mode)
      MODE_SMALL_SMALL: begin
        spare_bytes[7:0]   = block_low_next;
        spare_bytes[15:8]  = block_high_next;
        spare_bytes[47:40] = FILL_BYTE;
      end
      MODE_SMALL_BIG: begin
        spare_bytes[15:8]  = block_low_next;
        spare_bytes[23:16] = block_high_next;
        spare_bytes[47:40] = FILL_BYTE;
      end
      default: begin
        spare_bytes[7:0]  = FILL_BYTE;
        spare_bytes[15:8] = block_low_next;
      end
    endcase
  end

  assign job.edc       = edc_word;
  assign job.spare_low = spare_bytes;
  assign job.blank     = word_ch.page_blank;

  // mode register, edc and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      controller_mode <= MODE_SMALL_SMALL;
      edc_shift       <= '0;
      page_in_block   <= '0;
      block_low       <= '0;
      block_high      <= '0;
    end else begin
      if (cfg_wr_en) begin
        controller_mode <= cfg_wr_data;
      end
      if (word_take) begin
        if (word_ch.last_word) begin
          edc_shift     <= '0;
          page_in_block <= page_in_block_next;
          block_low     <= block_low_next;
          block_high    <= block_high_next;
        end else begin
          edc_shift <= edc_word;
        end
      end
    end
  end

  nsedc_spare_pipe u_spare_pipe (
    .clk       (clk),
    .rst       (rst),
    .job_load  (job_load),
    .job       (job),
    .job_ready (job_ready),
    .spare_ch  (spare_ch)
  );

  // small layouts never leave the low block byte at its wrap value
  `NSEDC_ASSERT_NEXT(a_small_low_wrap, job_load && small_mode, block_low != BLOCK_LOW_WRAP, "block_low left at wrap value")
  // the page count always advances past zero on a finished page
  `NSEDC_ASSERT_NEXT(a_page_advance, job_load, page_in_block != '0, "page_in_block zero after page end")
endmodule

`default_nettype wire

### dv/nand_page_spare_edc_builder_unit_test.sv
// ---------------------------------------------------------------------------
// nand_page_spare_edc_builder_unit_test
// Self-checking bench for the NAND page spare builder: pages of random words
// go in, every spare that comes out is compared with a spare computed here
// from the same words, the controller mode and the page and block counters.
// ---------------------------------------------------------------------------
`default_nettype none

module nand_page_spare_edc_builder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nsedc_pkg::*;

  // mode three is decoded like big-on-big
  localparam logic [MODE_W-1:0] MODE_BIG_ALT = 2'd3;

  localparam int PAGE_WORDS     = 128;
  localparam int SPARE_LATENCY  = 3;
  localparam int MAX_IDLE       = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [SPARE_W-1:0] lo;
    logic [SPARE_W-1:0] hi;
  } spare_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_wr_en;
  logic [MODE_W-1:0] cfg_wr_data;

  nsedc_word_if  word_ch ();
  nsedc_spare_if spare_ch ();

  nand_page_spare_edc_builder_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .word_ch     (word_ch.sink),
    .spare_ch    (spare_ch.source)
  );

  // shadow copy of the block state
  logic [EDC_W-1:0]  edc_run;
  logic [PAGE_W-1:0] page_cnt;
  logic [BYTE_W-1:0] blk_low;
  logic [BYTE_W-1:0] blk_high;
  logic [MODE_W-1:0] ctl_mode;

  spare_t spare_q[$];
  int     errors = 0;
  int     quiet_cycles = 0;
  bit     src_idle = 1'b1;
  bit     sink_idle = 1'b1;

  always #6 clk = ~clk;

  // shift n bits, lsb first, through the edc lfsr
  function automatic logic [EDC_W-1:0] edc_shift_bits(input logic [EDC_W-1:0] s,
                                                      input logic [WORD_W-1:0] bits,
                                                      input int n);
    logic [EDC_W:0] t;
    int k;
    t = {1'b0, s};
    for (k = 0; k < n; k++) begin
      t[0] = t[0] ^ bits[k];
      if (t[0]) begin
        t = t ^ EDC_POLY;
      end
      t = {1'b0, t[EDC_W:1]};
    end
    return t[EDC_W-1:0];
  endfunction

  // fold one accepted word; on a last word step counters and build the spare
  function automatic bit account_word(input logic [WORD_W-1:0] w, input logic last,
                                      input logic blank, output spare_t sp);
    logic [BYTE_W-1:0] b [16];
    logic [EDC_W-1:0]  s;
    logic [EDC_W-1:0]  edc;
    logic              small_blocks;
    int k;
    sp = '0;
    edc_run = edc_shift_bits(edc_run, ~w, WORD_W);
    if (!last) begin
      return 1'b0;
    end
    small_blocks = (ctl_mode == MODE_SMALL_SMALL) || (ctl_mode == MODE_SMALL_BIG);
    if (small_blocks) begin
      if (page_cnt >= SMALL_PAGES_PER_BLOCK) begin
        blk_low  = blk_low + 8'd1;
        page_cnt = '0;
      end
      if (blk_low == BLOCK_LOW_WRAP) begin
        blk_high = blk_high + 8'd1;
        blk_low  = '0;
      end
    end else if (page_cnt >= BIG_PAGES_PER_BLOCK) begin
      blk_low  = blk_low + 8'd1;
      page_cnt = '0;
    end
    if (blank) begin
      sp = '1;
    end else begin
      for (k = 0; k < 16; k++) begin
        b[k] = '0;
      end
      case (ctl_mode)
        MODE_SMALL_SMALL: begin
          b[0] = blk_low;
          b[1] = blk_high;
          b[5] = FILL_BYTE;
        end
        MODE_SMALL_BIG: begin
          b[1] = blk_low;
          b[2] = blk_high;
          b[5] = FILL_BYTE;
        end
        default: begin
          b[0] = FILL_BYTE;
          b[1] = blk_low;
        end
      endcase
      // edc runs on over spare bytes 0..11 and the low six bits of byte 12
      s = edc_run;
      for (k = 0; k < 3; k++) begin
        s = edc_shift_bits(s, ~{b[4*k+3], b[4*k+2], b[4*k+1], b[4*k]}, WORD_W);
      end
      s = edc_shift_bits(s, ~{b[15], b[14], b[13], b[12]}, TAIL_W);
      edc = ~s;
      b[12] = {edc[1:0], b[12][5:0]};
      b[13] = edc[9:2];
      b[14] = edc[17:10];
      b[15] = edc[25:18];
      sp.lo = {b[7], b[6], b[5], b[4], b[3], b[2], b[1], b[0]};
      sp.hi = {b[15], b[14], b[13], b[12], b[11], b[10], b[9], b[8]};
    end
    page_cnt = page_cnt + 9'd1;
    edc_run  = '0;
    return 1'b1;
  endfunction

  // predict on accepted words, compare accepted spares in order
  always @(posedge clk) begin : spare_check
    spare_t pred;
    spare_t got;
    spare_t want;
    if (!rst) begin
      if (word_ch.valid && word_ch.ready) begin
        if (account_word(word_ch.data_word, word_ch.last_word, word_ch.page_blank, pred)) begin
          spare_q.push_back(pred);
        end
      end
      if (spare_ch.valid && spare_ch.ready) begin
        got.lo = spare_ch.spare_low;
        got.hi = spare_ch.spare_high;
        if (spare_q.size() == 0) begin
          errors++;
          $display("%0t: spare item with no page pending, actual lo=%h hi=%h",
                   $time, got.lo, got.hi);
        end else begin
          want = spare_q.pop_front();
          if (got.lo !== want.lo) begin
            errors++;
            $display("%0t: spare_low expected %h actual %h", $time, want.lo, got.lo);
          end
          if (got.hi !== want.hi) begin
            errors++;
            $display("%0t: spare_high expected %h actual %h", $time, want.hi, got.hi);
          end
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (spare_ch.valid && spare_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // spare sink with random back-pressure
  initial begin : spare_sink
    int n;
    spare_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (n > 0) begin
        spare_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      spare_ch.ready <= 1'b1;
      do @(posedge clk); while (!spare_ch.valid);
      @(negedge clk);
    end
  end

  // data word with a bias toward all zeros and all ones
  function automatic logic [WORD_W-1:0] random_data();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  // drive one word item after a random gap and wait until it is taken
  task automatic send_word(input logic [WORD_W-1:0] w, input logic last, input logic blank);
    int gap;
    gap = src_idle ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      @(negedge clk);
      word_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    word_ch.valid      <= 1'b1;
    word_ch.data_word  <= w;
    word_ch.last_word  <= last;
    word_ch.page_blank <= blank;
    do @(posedge clk); while (!word_ch.ready);
  endtask

  // one page of random words; the blank flag on inner words is noise
  task automatic send_page(input int len, input logic blank);
    int k;
    for (k = 0; k < len - 1; k++) begin
      send_word(random_data(), 1'b0, $urandom_range(0, 3) == 0);
    end
    send_word(random_data(), 1'b1, blank);
  endtask

  // stop sending, let every pending spare come out, then let the pipe settle
  task automatic drain_spares();
    @(negedge clk);
    word_ch.valid <= 1'b0;
    while (spare_q.size() != 0) @(posedge clk);
    repeat (SPARE_LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_mode(input logic [MODE_W-1:0] m);
    drain_spares();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    ctl_mode = m;
  endtask

  // corner words, blank pages and every mode, two-word pages in small modes
  task automatic test_directed();
    send_word(32'h0000_0000, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(32'h8000_0001, 1'b1, 1'b1);
    send_word(32'hA5A5_A5A5, 1'b0, 1'b1);
    send_word(32'h5A5A_5A5A, 1'b1, 1'b0);
    set_mode(MODE_SMALL_BIG);
    send_word(32'h0000_0000, 1'b1, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(32'h1234_5678, 1'b0, 1'b0);
    send_word(32'h8765_4321, 1'b1, 1'b0);
    set_mode(MODE_BIG_BIG);
    send_word(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_word(32'h0000_0001, 1'b1, 1'b0);
    set_mode(MODE_BIG_ALT);
    send_word(32'hDEAD_BEEF, 1'b1, 1'b0);
    send_word(32'h0000_0000, 1'b1, 1'b1);
  endtask

  // single-word pages back to back over a few small blocks, then a
  // big-block rollover and a counter left above the small limit by the
  // mode change
  task automatic test_block_walk();
    int k;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    set_mode(MODE_SMALL_SMALL);
    for (k = 0; k < 70; k++) begin
      send_page(1, $urandom_range(0, 15) == 0);
    end
    set_mode(MODE_BIG_BIG);
    for (k = 0; k < 290; k++) begin
      send_page(1, $urandom_range(0, 15) == 0);
    end
    set_mode(MODE_SMALL_BIG);
    for (k = 0; k < 40; k++) begin
      send_page(1, $urandom_range(0, 15) == 0);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  // phases of random pages, mostly short, some full and a few overlong
  task automatic test_random_pages();
    int phase;
    int sent;
    int len;
    int pick;
    logic [MODE_W-1:0] m;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: m = MODE_BIG_ALT;
        1: m = MODE_SMALL_SMALL;
        2: m = MODE_BIG_BIG;
        3: m = MODE_SMALL_BIG;
        default: m = MODE_W'($urandom_range(0, 3));
      endcase
      set_mode(m);
      src_idle  = $urandom_range(0, 3) != 0;
      sink_idle = $urandom_range(0, 3) != 0;
      sent = 0;
      while (sent < 180) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          len = $urandom_range(1, 8);
        end else if (pick < 90) begin
          len = $urandom_range(9, 40);
        end else if (pick < 98) begin
          len = PAGE_WORDS;
        end else begin
          len = $urandom_range(PAGE_WORDS + 1, PAGE_WORDS + 12);
        end
        send_page(len, $urandom_range(0, 7) == 0);
        sent += len;
      end
    end
  endtask

  initial begin
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    word_ch.valid      = 1'b0;
    word_ch.data_word  = '0;
    word_ch.last_word  = 1'b0;
    word_ch.page_blank = 1'b0;
    edc_run  = '0;
    page_cnt = '0;
    blk_low  = '0;
    blk_high = '0;
    ctl_mode = MODE_SMALL_SMALL;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_block_walk();
    test_random_pages();

    drain_spares();
    repeat (4 * SPARE_LATENCY) @(posedge clk);
    if (errors == 0 && spare_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
